// ===== sv/rc4sc_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared types and constants for the RC4 stream cipher block: sequencer
// states, adder operations and the operand bundle fed to the shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4sc_pkg;

	localparam int BYTE_W    = 8;
	localparam int PERM_SIZE = 256;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_K0,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_K4,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5
	} state_t;

	typedef enum logic [1:0] {
		ALU_INC_I,
		ALU_J_RD,
		ALU_ACC_KEY,
		ALU_SUM_S
	} alu_op_t;

	typedef struct packed {
		byte_t idx_i;
		byte_t idx_j;
		byte_t acc;
		byte_t si;
		byte_t sj;
		byte_t rd;
		byte_t key;
	} alu_opnd_t;

endpackage

`default_nettype wire

// ===== sv/rc4sc_ram.sv =====
// ----------------------------------------------------------------------------
// rc4sc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/rc4sc_alu.sv =====
// ----------------------------------------------------------------------------
// rc4sc_alu
// Shared 8-bit modulo-256 adder with operand selection for the j index sums of
// the key schedule and the keystream generator, the keystream i index and sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sc_alu (
	input  wire rc4sc_pkg::alu_op_t   op,
	input  wire rc4sc_pkg::alu_opnd_t opnd,
	output rc4sc_pkg::byte_t          sum
);

	import rc4sc_pkg::*;

	byte_t op_a;
	byte_t op_b;

	always_comb begin
		case (op)
			ALU_INC_I: begin
				op_a = opnd.idx_i;
				op_b = byte_t'(1);
			end
			ALU_J_RD: begin
				op_a = opnd.idx_j;
				op_b = opnd.rd;
			end
			ALU_ACC_KEY: begin
				op_a = opnd.acc;
				op_b = opnd.key;
			end
			ALU_SUM_S: begin
				op_a = opnd.si;
				op_b = opnd.sj;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign sum = op_a + op_b;

endmodule

`default_nettype wire

// ===== sv/rc4_stream_cipher.sv =====
// Data byte: accepted in idle, then stepped through ST_P0 to ST_P5; the result
//   is registered in out_byte as ST_P5 finds the output slot free, and the next
//   item is taken only after the return to idle (one data byte at a time).
// Key byte: taken in idle without leaving it. Last key byte: scheduling (256
//   identity writes, then ST_K0 to ST_K4 for each of 256 entries); the next
//   item is taken only after the return to idle.
// Reset clears indices, key count and the keyed flag; RAM contents undefined.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 key schedule and keystream generator around one permutation RAM, one
// key RAM and a shared adder, driven by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
	parameter int KEY_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic kind,
	input  wire logic [7:0] value,
	input  wire logic last,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] out_byte
);

	import rc4sc_pkg::*;

	localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CW = $clog2(KEY_DEPTH + 1);

	state_t        state_q, state_d;
	alu_op_t       alu_op;
	alu_opnd_t     alu_opnd;
	byte_t         alu_sum;

	byte_t         idx_i_q, idx_j_q, n_q;
	logic [KW-1:0] kpos_q;
	logic [CW-1:0] key_cnt_q;
	logic          keyed_q;
	logic          out_valid_q;
	byte_t         out_byte_q;
	byte_t         val_q, si_q, sj_q, acc_q;

	logic          perm_we;
	byte_t         perm_waddr, perm_wdata, perm_raddr, perm_rd;
	logic          key_we;
	byte_t         key_rd;

	logic          in_acc;
	logic          key_room;
	logic          out_free;
	logic [CW:0]   kpos_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign key_room  = (key_cnt_q < CW'(KEY_DEPTH));
	assign key_we    = in_acc && !kind && key_room;
	assign out_free  = !out_valid_q || !out_stall;
	assign kpos_nx   = (CW+1)'(kpos_q) + 1'b1;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	assign alu_opnd = '{idx_i: idx_i_q, idx_j: idx_j_q, acc: acc_q, si: si_q,
		sj: sj_q, rd: perm_rd, key: key_rd};

	rc4sc_alu u_alu (
		.op   (alu_op),
		.opnd (alu_opnd),
		.sum  (alu_sum)
	);

	rc4sc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PERM_SIZE)
	) u_perm_ram (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.raddr (perm_raddr),
		.rdata (perm_rd)
	);

	rc4sc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (KEY_DEPTH),
		.AW    (KW)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_cnt_q[KW-1:0]),
		.wdata (value),
		.raddr (kpos_q),
		.rdata (key_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		alu_op     = ALU_INC_I;
		perm_we    = 1'b0;
		perm_waddr = n_q;
		perm_wdata = n_q;
		perm_raddr = n_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!kind && last) begin
						state_d = ST_INIT;
					end else if (kind && keyed_q) begin
						state_d = ST_P0;
					end
				end
			end
			ST_INIT: begin
				perm_we = 1'b1;
				if (n_q == '1) begin
					state_d = ST_K0;
				end
			end
			ST_K0: begin
				state_d = ST_K1;
			end
			ST_K1: begin
				alu_op  = ALU_J_RD;
				state_d = ST_K2;
			end
			ST_K2: begin
				alu_op     = ALU_ACC_KEY;
				perm_raddr = alu_sum;
				state_d    = ST_K3;
			end
			ST_K3: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rd;
				state_d    = ST_K4;
			end
			ST_K4: begin
				perm_we    = 1'b1;
				perm_waddr = idx_j_q;
				perm_wdata = si_q;
				state_d    = (n_q == '1) ? ST_IDLE : ST_K0;
			end
			ST_P0: begin
				alu_op     = ALU_INC_I;
				perm_raddr = alu_sum;
				state_d    = ST_P1;
			end
			ST_P1: begin
				alu_op     = ALU_J_RD;
				perm_raddr = alu_sum;
				state_d    = ST_P2;
			end
			ST_P2: begin
				perm_we    = 1'b1;
				perm_waddr = idx_i_q;
				perm_wdata = perm_rd;
				state_d    = ST_P3;
			end
			ST_P3: begin
				perm_we    = 1'b1;
				perm_waddr = idx_j_q;
				perm_wdata = si_q;
				state_d    = ST_P4;
			end
			ST_P4: begin
				alu_op     = ALU_SUM_S;
				perm_raddr = alu_sum;
				state_d    = ST_P5;
			end
			ST_P5: begin
				// hold the keystream read address until the output slot frees
				alu_op     = ALU_SUM_S;
				perm_raddr = alu_sum;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_i_q     <= '0;
			idx_j_q     <= '0;
			n_q         <= '0;
			kpos_q      <= '0;
			key_cnt_q   <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result as the slot frees, drop a taken one
			if (state_q == ST_P5 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (key_we) begin
						key_cnt_q <= key_cnt_q + 1'b1;
					end
					if (in_acc && !kind && last) begin
						n_q     <= '0;
						idx_j_q <= '0;
						kpos_q  <= '0;
					end
				end
				ST_INIT: begin
					n_q <= n_q + 1'b1;
				end
				ST_K2: begin
					idx_j_q <= alu_sum;
				end
				ST_K4: begin
					n_q <= n_q + 1'b1;
					// wrap the key position at the stored key length
					if (kpos_nx >= {1'b0, key_cnt_q}) begin
						kpos_q <= '0;
					end else begin
						kpos_q <= kpos_nx[KW-1:0];
					end
					if (n_q == '1) begin
						idx_i_q   <= '0;
						idx_j_q   <= '0;
						key_cnt_q <= '0;
						keyed_q   <= 1'b1;
					end
				end
				ST_P0: begin
					idx_i_q <= alu_sum;
				end
				ST_P1: begin
					idx_j_q <= alu_sum;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					val_q <= value;
				end
			end
			ST_K1: begin
				si_q  <= perm_rd;
				acc_q <= alu_sum;
			end
			ST_P1: begin
				si_q <= perm_rd;
			end
			ST_P2: begin
				sj_q <= perm_rd;
			end
			ST_P5: begin
				if (out_free) begin
					out_byte_q <= val_q ^ perm_rd;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/rc4sc_check.sv =====
// ----------------------------------------------------------------------------
// rc4sc_check
// Port-level checks for the RC4 stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4sc_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       kind,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte
);

	// a last key byte starts scheduling: stall the input next cycle
	a_last_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !kind && last) |=> in_stall)
		else $error("no schedule after last key byte");

	// a plain key byte leaves the input free in the next cycle
	a_key_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !kind && !last) |=> !in_stall)
		else $error("busy after plain key byte");

	// a new result only comes out of a busy sequence
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
		else $error("stalled result dropped or changed");

endmodule

bind rc4_stream_cipher rc4sc_check u_rc4sc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte)
);

`default_nettype wire
